// ===== rtl/gpl_pkg.sv =====
// Package for the grid pattern lock: status codes, key codes and register indexes.
package gpl_pkg;

  // Result status codes
  typedef enum logic [3:0] {
    ST_MOVED   = 4'd0,
    ST_BADKEY  = 4'd1,
    ST_EDGE    = 4'd2,
    ST_ACCEPT  = 4'd3,
    ST_WRONG   = 4'd4,
    ST_LOCKOUT = 4'd5,
    ST_SAVED   = 4'd6,
    ST_SAME    = 4'd7,
    ST_LOCKED  = 4'd8
  } status_e;

  // Cursor moves decoded from the key byte
  typedef enum logic [2:0] {
    DIR_NONE,
    DIR_UP,
    DIR_LEFT,
    DIR_DOWN,
    DIR_RIGHT
  } dir_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ATTEMPTS = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENROLL_MODE  = 1'd1;
  localparam int unsigned CfgDataW = 3;

  // Field widths at the ports
  localparam int unsigned KeyW     = 8;
  localparam int unsigned StatusW  = 4;
  localparam int unsigned SymOutW  = 5;
  localparam int unsigned MovesW   = 4;
  localparam int unsigned FailW    = 3;

  localparam logic [FailW-1:0] FAIL_SAT = 3'd7;
  localparam logic [FailW-1:0] MAX_ATTEMPTS_RST = 3'd3;

  // Key bytes (ASCII)
  localparam logic [KeyW-1:0] KEY_W_LC = 8'h77;
  localparam logic [KeyW-1:0] KEY_W_UC = 8'h57;
  localparam logic [KeyW-1:0] KEY_A_LC = 8'h61;
  localparam logic [KeyW-1:0] KEY_A_UC = 8'h41;
  localparam logic [KeyW-1:0] KEY_S_LC = 8'h73;
  localparam logic [KeyW-1:0] KEY_S_UC = 8'h53;
  localparam logic [KeyW-1:0] KEY_D_LC = 8'h64;
  localparam logic [KeyW-1:0] KEY_D_UC = 8'h44;

endpackage

// ===== rtl/grid_pattern_lock.sv =====
// Grid pattern lock: W/A/S/D cursor entry of a code, verify and enroll against a stored code.
//
// Usage
//   Input channel (in_valid_i / in_ready_o, key_code_i) carries one key byte per
//   transaction. Each key yields exactly one result transaction on the output
//   channel (out_valid_o / out_ready_i) with status_o, symbol_o, moves_done_o and
//   failures_o.
//   Configuration channel (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i) is
//   always ready; index 0 is max_attempts, index 1 is enroll_mode. Write it only
//   while no result is outstanding.
//   A result is registered and presented in the cycle after its key is taken.
//   Throughput: one key per cycle while no result stalls. The whole step (decode,
//   visit check, full code compare) is a single pass of logic into the result
//   register, and the result register frees itself in the same cycle it is drained.
//   Stall: while a result waits with out_ready_i low, in_ready_o drops, so no key
//   is lost; the next key is taken in the cycle the waiting result leaves.
//   Reset: cursor at top-left, only that cell visited, no moves, no failures,
//   stored code all zeros (no verify succeeds until a code is enrolled), lockout
//   clear, max_attempts 3, verify mode. Only reset clears a lockout.
module grid_pattern_lock #(
  parameter int unsigned CODE_LEN  = 10,
  parameter int unsigned GRID_SIDE = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gpl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gpl_pkg::CfgDataW-1:0]  cfg_data_i,
  // key input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gpl_pkg::KeyW-1:0]      key_code_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gpl_pkg::StatusW-1:0]   status_o,
  output logic [gpl_pkg::SymOutW-1:0]   symbol_o,
  output logic [gpl_pkg::MovesW-1:0]    moves_done_o,
  output logic [gpl_pkg::FailW-1:0]     failures_o
);
  import gpl_pkg::*;

  localparam int unsigned NumCells = GRID_SIDE * GRID_SIDE;
  localparam int unsigned PosW     = $clog2(GRID_SIDE);
  localparam int unsigned CellW    = $clog2(NumCells);
  localparam int unsigned SymW     = $clog2(NumCells + 1);
  localparam int unsigned CntW     = $clog2(CODE_LEN);
  localparam logic [PosW-1:0] PosLast   = PosW'(GRID_SIDE - 1);
  localparam logic [CntW-1:0] CntLast   = CntW'(CODE_LEN - 1);
  localparam logic [SymW-1:0] RevisitSym = SymW'(NumCells);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [FailW-1:0]    max_att_q;
  logic                enroll_q;
  logic [PosW-1:0]     row_q, row_d;
  logic [PosW-1:0]     col_q, col_d;
  logic [NumCells-1:0] visited_q, visited_d;
  logic [CntW-1:0]     mcount_q, mcount_d;
  logic [FailW-1:0]    fail_q, fail_d;
  logic                locked_q, locked_d;
  // Entry 0 of both codes is always the top-left cell, so only 1..CODE_LEN-1 are kept.
  logic [SymW-1:0]     entered_q [1:CODE_LEN-1];
  logic [SymW-1:0]     stored_q  [1:CODE_LEN-1];
  logic [SymW-1:0]     code_vec  [1:CODE_LEN-1];
  logic                wr_entry;
  logic                save_code;

  // Result register
  logic                out_valid_q;
  status_e             status_q, status_d;
  logic [SymW-1:0]     sym_q, sym_d;
  logic [CntW-1:0]     moves_q, moves_d;
  logic [FailW-1:0]    failo_q;

  logic in_fire;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Single-pass step logic
  // ---------------------------------------------------------------------------
  dir_e            dir;
  logic            at_edge;
  logic [PosW-1:0] row_n, col_n;
  logic [CellW-1:0] cell_idx;
  logic [SymW-1:0] sym;
  logic [CntW-1:0] mc_next;
  logic            complete;
  logic            same;
  logic [FailW-1:0] fail_inc;

  always_comb begin
    unique case (key_code_i)
      KEY_W_LC, KEY_W_UC: dir = DIR_UP;
      KEY_A_LC, KEY_A_UC: dir = DIR_LEFT;
      KEY_S_LC, KEY_S_UC: dir = DIR_DOWN;
      KEY_D_LC, KEY_D_UC: dir = DIR_RIGHT;
      default:            dir = DIR_NONE;
    endcase
  end

  always_comb begin
    row_n   = row_q;
    col_n   = col_q;
    at_edge = 1'b0;
    unique case (dir)
      DIR_UP: begin
        at_edge = (row_q == '0);
        row_n   = row_q - PosW'(1);
      end
      DIR_LEFT: begin
        at_edge = (col_q == '0);
        col_n   = col_q - PosW'(1);
      end
      DIR_DOWN: begin
        at_edge = (row_q == PosLast);
        row_n   = row_q + PosW'(1);
      end
      DIR_RIGHT: begin
        at_edge = (col_q == PosLast);
        col_n   = col_q + PosW'(1);
      end
      default: at_edge = 1'b0;
    endcase
  end

  assign cell_idx = CellW'(int'(row_n) * GRID_SIDE + int'(col_n));
  assign sym      = visited_q[cell_idx] ? RevisitSym : SymW'(cell_idx);
  assign mc_next  = mcount_q + CntW'(1);
  assign complete = (mc_next == CntLast);
  assign fail_inc = (fail_q == FAIL_SAT) ? FAIL_SAT : fail_q + FailW'(1);

  // Code as it stands once this move's symbol is in.
  always_comb begin
    for (int i = 1; i < CODE_LEN; i++) begin
      code_vec[i] = (mc_next == CntW'(i)) ? sym : entered_q[i];
    end
  end

  // Parallel compare of the full code.
  always_comb begin
    same = 1'b1;
    for (int i = 1; i < CODE_LEN; i++) begin
      if (code_vec[i] != stored_q[i]) same = 1'b0;
    end
  end

  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    visited_d = visited_q;
    mcount_d  = mcount_q;
    fail_d    = fail_q;
    locked_d  = locked_q;
    wr_entry  = 1'b0;
    save_code = 1'b0;
    status_d  = ST_MOVED;
    sym_d     = '0;
    moves_d   = mcount_q;

    priority if (locked_q) begin
      status_d = ST_LOCKED;
    end else if (dir == DIR_NONE) begin
      status_d = ST_BADKEY;
    end else if (at_edge) begin
      status_d = ST_EDGE;
    end else if (!complete) begin
      row_d     = row_n;
      col_d     = col_n;
      visited_d = visited_q | (NumCells'(1) << cell_idx);
      mcount_d  = mc_next;
      wr_entry  = 1'b1;
      status_d  = ST_MOVED;
      sym_d     = sym;
      moves_d   = mc_next;
    end else begin
      // Code complete: judge it, then restart the entry at top-left.
      row_d     = '0;
      col_d     = '0;
      visited_d = NumCells'(1);
      mcount_d  = '0;
      sym_d     = sym;
      moves_d   = CntLast;
      if (enroll_q) begin
        if (same) begin
          status_d = ST_SAME;
        end else begin
          save_code = 1'b1;
          status_d  = ST_SAVED;
        end
      end else if (same) begin
        fail_d   = '0;
        status_d = ST_ACCEPT;
      end else begin
        fail_d = fail_inc;
        if (fail_inc >= max_att_q) begin
          locked_d = 1'b1;
          status_d = ST_LOCKOUT;
        end else begin
          status_d = ST_WRONG;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_att_q <= MAX_ATTEMPTS_RST;
      enroll_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MAX_ATTEMPTS: max_att_q <= cfg_data_i[FailW-1:0];
        CFG_ENROLL_MODE:  enroll_q  <= cfg_data_i[0];
        default:          max_att_q <= max_att_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      visited_q <= NumCells'(1);
      mcount_q  <= '0;
      fail_q    <= '0;
      locked_q  <= 1'b0;
    end else if (in_fire) begin
      row_q     <= row_d;
      col_q     <= col_d;
      visited_q <= visited_d;
      mcount_q  <= mcount_d;
      fail_q    <= fail_d;
      locked_q  <= locked_d;
    end
  end

  // Entered symbols: slots 1..CODE_LEN-2 are rewritten before the code completes; the last comes from sym.
  always_ff @(posedge clk_i) begin
    if (in_fire && wr_entry) begin
      for (int i = 1; i < CODE_LEN; i++) begin
        if (mc_next == CntW'(i)) entered_q[i] <= sym;
      end
    end
  end

  // Stored code resets to zeros: nothing can verify before an enrolment.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i < CODE_LEN; i++) stored_q[i] <= '0;
    end else if (in_fire && save_code) begin
      for (int i = 1; i < CODE_LEN; i++) stored_q[i] <= code_vec[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      sym_q    <= sym_d;
      moves_q  <= moves_d;
      failo_q  <= fail_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign symbol_o     = SymOutW'(sym_q);
  assign moves_done_o = MovesW'(moves_q);
  assign failures_o   = failo_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |=> locked_q)
    else $error("lockout cleared without reset");

  a_lockout_sets_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && status_d == ST_LOCKOUT) |=> locked_q)
    else $error("lockout status without lock");

  a_entry_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcount_q < CntLast)
    else $error("move count reached code length without restart");

  a_start_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    visited_q[0])
    else $error("top-left cell not marked visited");

  a_locked_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && locked_q) |=> ($stable(mcount_q) && $stable(fail_q)))
    else $error("state moved while locked out");

endmodule

// ===== test/grid_pattern_lock_tb.sv =====
// Self-checking testbench for grid_pattern_lock: key traffic with random pacing and result checks.
`timescale 1ns / 1ps

module grid_pattern_lock_tb;
  import gpl_pkg::*;

  localparam int CodeLen    = 10;
  localparam int GridSide   = 4;
  localparam int NumCells   = GridSide * GridSide;
  localparam int RevisitSym = NumCells;
  localparam int CycleLimit = 400_000;

  // Random part: one register setting per phase, about this many keys each
  localparam int NumPhases    = 8;
  localparam int KeysPerPhase = 85;
  localparam logic [FailW-1:0] PhaseAttempts [NumPhases] =
    '{3'd7, 3'd7, 3'd4, 3'd2, 3'd5, 3'd1, 3'd6, 3'd2};
  localparam logic PhaseEnroll [NumPhases] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam dir_e MoveDirs [4] = '{DIR_UP, DIR_LEFT, DIR_DOWN, DIR_RIGHT};

  typedef enum {ENTRY_REPLAY, ENTRY_DEVIATE, ENTRY_WALK, ENTRY_WILD} entry_kind_e;

  typedef struct packed {
    status_e                  status;
    logic [SymOutW-1:0]       symbol;
    logic [MovesW-1:0]        moves;
    logic [FailW-1:0]         failures;
  } lock_result_t;

  // Shadow copy of the lock: cursor, visit map, codes, failure count and lockout.
  // take_key() advances it for each key transaction and queues the result due.
  class lock_state;
    logic [FailW-1:0]   max_attempts;
    logic               enroll_mode;
    int                 row;
    int                 col;
    logic [NumCells-1:0] visited;
    logic [SymOutW-1:0] entered [CodeLen];
    logic [SymOutW-1:0] stored [CodeLen];
    int                 moves;
    logic [FailW-1:0]   fails;
    bit                 locked;
    int                 codes_done;
    status_e            last_status;
    lock_result_t       due_results [$];
    int                 mismatches;

    function new();
      max_attempts = MAX_ATTEMPTS_RST;
      enroll_mode  = 1'b0;
      fails        = '0;
      locked       = 1'b0;
      codes_done   = 0;
      mismatches   = 0;
      foreach (stored[i]) stored[i] = '0;
      restart_entry();
    endfunction

    function void restart_entry();
      row = 0;
      col = 0;
      visited = NumCells'(1);
      foreach (entered[i]) entered[i] = '0;
      moves = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CFG_MAX_ATTEMPTS) max_attempts = data;
      else if (idx == CFG_ENROLL_MODE) enroll_mode = data[0];
    endfunction

    function dir_e dir_of(logic [KeyW-1:0] key);
      case (key)
        KEY_W_LC, KEY_W_UC: return DIR_UP;
        KEY_A_LC, KEY_A_UC: return DIR_LEFT;
        KEY_S_LC, KEY_S_UC: return DIR_DOWN;
        KEY_D_LC, KEY_D_UC: return DIR_RIGHT;
        default:            return DIR_NONE;
      endcase
    endfunction

    function bit can_move(dir_e d);
      case (d)
        DIR_UP:    return row > 0;
        DIR_LEFT:  return col > 0;
        DIR_DOWN:  return row < GridSide - 1;
        DIR_RIGHT: return col < GridSide - 1;
        default:   return 1'b0;
      endcase
    endfunction

    function void take_key(logic [KeyW-1:0] key);
      dir_e               d;
      int                 cell_idx;
      logic [SymOutW-1:0] sym;
      bit                 same;
      bit                 complete;
      lock_result_t       res;
      d        = dir_of(key);
      sym      = '0;
      complete = 1'b0;
      if (locked) last_status = ST_LOCKED;
      else if (d == DIR_NONE) last_status = ST_BADKEY;
      else if (!can_move(d)) last_status = ST_EDGE;
      else begin
        case (d)
          DIR_UP:    row--;
          DIR_LEFT:  col--;
          DIR_DOWN:  row++;
          default:   col++;
        endcase
        cell_idx = row * GridSide + col;
        sym = visited[cell_idx] ? SymOutW'(RevisitSym) : SymOutW'(cell_idx);
        visited[cell_idx] = 1'b1;
        moves++;
        if (moves < CodeLen) entered[moves] = sym;
        last_status = ST_MOVED;
        if (moves == CodeLen - 1) begin
          complete = 1'b1;
          codes_done++;
          same = 1'b1;
          foreach (entered[i]) if (entered[i] != stored[i]) same = 1'b0;
          if (enroll_mode) begin
            if (same) last_status = ST_SAME;
            else begin
              stored = entered;
              last_status = ST_SAVED;
            end
          end else if (same) begin
            fails = '0;
            last_status = ST_ACCEPT;
          end else begin
            if (fails != FAIL_SAT) fails++;
            if (fails >= max_attempts) begin
              locked = 1'b1;
              last_status = ST_LOCKOUT;
            end else begin
              last_status = ST_WRONG;
            end
          end
        end
      end
      res.status   = last_status;
      res.symbol   = sym;
      res.moves    = MovesW'(moves);
      res.failures = fails;
      due_results.push_back(res);
      if (complete) restart_entry();
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [StatusW-1:0] status, logic [SymOutW-1:0] symbol,
                               logic [MovesW-1:0] moves_done, logic [FailW-1:0] failures);
      lock_result_t want;
      if (due_results.size() == 0) begin
        $error("result transaction with nothing due: status %0d symbol %0d", status, symbol);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare_field("status", want.status, status);
      compare_field("symbol", want.symbol, symbol);
      compare_field("moves_done", want.moves, moves_done);
      compare_field("failures", want.failures, failures);
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [KeyW-1:0]     key_code_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [SymOutW-1:0]  symbol_o;
  logic [MovesW-1:0]   moves_done_o;
  logic [FailW-1:0]    failures_o;

  lock_state       sb;
  int              keys_sent   = 0;
  int              burst_left  = 0;
  int              cycle_count = 0;
  logic [7:0]      stall_phase = '0;
  // key path of the current entry, and the one behind the stored code
  logic [KeyW-1:0] path_now [$];
  logic [KeyW-1:0] stored_path [$];

  grid_pattern_lock #(
    .CODE_LEN (CodeLen),
    .GRID_SIDE(GridSide)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .key_code_i  (key_code_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .symbol_o    (symbol_o),
    .moves_done_o(moves_done_o),
    .failures_o  (failures_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side back-pressure: four modes in turn, picked by stall_phase[7:6] - always ready,
  // coin toss, long stalls (ready only when stall_phase[2:0] is zero), and mostly ready.
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 8'd1;
    case (stall_phase[7:6])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= ($urandom_range(0, 1) == 1);
      2'd2:    out_ready_i <= (stall_phase[2:0] == 3'd0);
      default: out_ready_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Sampled in the active region at the edge, so both sides see pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, symbol_o, moves_done_o, failures_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("grid_pattern_lock_tb: errors");
      $finish;
    end
  end

  function automatic logic [KeyW-1:0] key_for(dir_e d, bit upper);
    case (d)
      DIR_UP:    return upper ? KEY_W_UC : KEY_W_LC;
      DIR_LEFT:  return upper ? KEY_A_UC : KEY_A_LC;
      DIR_DOWN:  return upper ? KEY_S_UC : KEY_S_LC;
      default:   return upper ? KEY_D_UC : KEY_D_LC;
    endcase
  endfunction

  function automatic logic [KeyW-1:0] bad_key();
    logic [KeyW-1:0] k;
    do k = KeyW'($urandom_range(0, 255)); while (sb.dir_of(k) != DIR_NONE);
    return k;
  endfunction

  // A key that moves from the current cell (legal) or runs into an edge;
  // falls back to a non-move byte when no edge is adjacent.
  function automatic logic [KeyW-1:0] pick_key(bit legal);
    dir_e opts [$];
    foreach (MoveDirs[i]) begin
      if (sb.can_move(MoveDirs[i]) == legal) opts.push_back(MoveDirs[i]);
    end
    if (opts.size() == 0) return bad_key();
    return key_for(opts[$urandom_range(0, opts.size() - 1)], 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [KeyW-1:0] wild_key();
    if ($urandom_range(0, 1))
      return key_for(MoveDirs[$urandom_range(0, 3)], 1'($urandom_range(0, 1)));
    return KeyW'($urandom_range(0, 255));
  endfunction

  // One key transaction. The sender runs in bursts; valid drops only for a gap,
  // so it is never lowered and raised in the same step.
  task automatic send_key(input logic [KeyW-1:0] k);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    key_code_i <= k;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_key(k);
    keys_sent++;
    // keep the path that produced the stored code, for later replays
    if (sb.last_status == ST_MOVED) path_now.push_back(k);
    else if (sb.last_status inside {ST_ACCEPT, ST_WRONG, ST_LOCKOUT, ST_SAVED, ST_SAME}) begin
      path_now.push_back(k);
      if (sb.last_status == ST_SAVED) stored_path = path_now;
      path_now.delete();
    end
  endtask

  // One complete code entry, with bad keys and edge bumps sprinkled in
  task automatic play_entry(input entry_kind_e kind);
    int              start;
    int              bend;
    logic [KeyW-1:0] k;
    start = sb.codes_done;
    bend  = $urandom_range(0, CodeLen - 2);
    while (sb.codes_done == start) begin
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(0, 1) ? pick_key(1'b0) : bad_key();
      end else begin
        case (kind)
          ENTRY_REPLAY:  k = stored_path[sb.moves];
          ENTRY_DEVIATE: k = (sb.moves < bend) ? stored_path[sb.moves] : pick_key(1'b1);
          ENTRY_WALK:    k = pick_key(1'b1);
          default:       k = wild_key();
        endcase
      end
      send_key(k);
    end
  endtask

  // Drain: no key offered, every due result back, then an idle pause
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [FailW-1:0] attempts, input logic enroll);
    wait_idle();
    write_reg(CFG_MAX_ATTEMPTS, attempts);
    // upper data bits are don't-care for the mode register
    write_reg(CFG_ENROLL_MODE, {2'($urandom_range(0, 3)), enroll});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [KeyW-1:0] opening [17];
    logic [KeyW-1:0] first_code [CodeLen-1];
    entry_kind_e     kind;
    int              target;
    int              roll;

    // Reset values, verify mode, nothing enrolled: non-move bytes, all grid
    // edges, both letter cases, a revisited cell, and a code that must fail
    opening = '{8'h00, 8'hFF, KEY_W_LC, KEY_W_UC, KEY_A_LC, KEY_A_UC,
                KEY_D_LC, KEY_D_UC, KEY_D_LC, KEY_D_UC,
                KEY_S_LC, KEY_S_UC, KEY_S_LC, KEY_S_UC,
                KEY_A_LC, KEY_W_UC, KEY_D_LC};
    // first enrolment, ends on a revisit
    first_code = '{KEY_D_UC, KEY_S_LC, KEY_A_UC, KEY_S_UC, KEY_D_LC,
                   KEY_D_UC, KEY_W_LC, KEY_W_UC, KEY_A_LC};

    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_key(opening[i]);
    configure(3'd7, 1'b1);
    foreach (first_code[i]) send_key(first_code[i]);

    // Mostly well-formed entries. In verify mode an entry that may be wrong is
    // only tried while one more failure stays short of the lockout.
    for (int p = 0; p < NumPhases; p++) begin
      configure(PhaseAttempts[p], PhaseEnroll[p]);
      target = keys_sent + KeysPerPhase;
      while (keys_sent < target) begin
        roll = $urandom_range(0, 7);
        if (sb.enroll_mode)
          kind = (roll < 2) ? ENTRY_REPLAY : (roll < 6) ? ENTRY_WALK : ENTRY_WILD;
        else if (sb.fails + 1 < sb.max_attempts)
          kind = (roll < 4) ? ENTRY_REPLAY : (roll < 6) ? ENTRY_DEVIATE :
                 (roll == 6) ? ENTRY_WALK : ENTRY_WILD;
        else
          kind = ENTRY_REPLAY;
        play_entry(kind);
      end
    end

    // Zero attempts allowed: the first wrong code locks out, then everything is refused
    configure(3'd0, 1'b0);
    while (!sb.locked) play_entry(ENTRY_WALK);
    repeat (16) send_key(wild_key());

    wait_idle();
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("grid_pattern_lock_tb: clean");
    end else begin
      $display("grid_pattern_lock_tb: errors");
    end
    $finish;
  end

endmodule
